// ----- rtl/core/dftc_pkg.sv -----
`default_nettype none
package dftc_pkg;

    localparam int DivW     = 32;   // dividend / quotient width of every divide
    localparam int DivisorW = 8;    // divisor width (frame rate)
    localparam int CorrW    = 19;   // corrected counts stay below 2**19
    localparam int CfgIdxW  = 2;

    localparam int CorrPassesDefault = 6;

    localparam logic [CfgIdxW-1:0] RegFrameRate = 2'd0;
    localparam logic [CfgIdxW-1:0] RegDropMode  = 2'd1;

    localparam logic [7:0]  FrameRateReset = 8'd30;
    localparam logic        DropModeReset  = 1'b1;

    localparam logic [7:0]  DfRate   = 8'd30;
    localparam logic [31:0] DfLimit  = 32'd300000;
    localparam logic [DivisorW-1:0] BaseSixty = 8'd60;

    // floor(x / 1800) = ((x >> 3) * Recip1800) >> 24 for x < 2**19
    localparam logic [16:0] Recip1800 = 17'd74566;
    // floor(x / 18000) = ((x >> 4) * Recip18000) >> 25 for x < 2**19
    localparam logic [14:0] Recip18000 = 15'd29827;
    // floor(x / 60) = ((x >> 2) * Recip60) >> 34 for x < 2**32
    localparam logic [30:0] Recip60 = 31'd1145324613;

    typedef struct packed {
        logic       neg;
        logic       drop;
        logic [7:0] rate;
    } side_t;

    localparam int SideW = $bits(side_t);

endpackage
`default_nettype wire

// ----- rtl/core/dftc_corr.sv -----
`default_nettype none
// Drop-frame correction, one fixed-point pass per pipeline stage.
module dftc_corr #(
    parameter int Passes = dftc_pkg::CorrPassesDefault
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [31:0]           mag,
    input  wire logic                  apply,
    input  wire dftc_pkg::side_t       side_in,
    output logic                       out_valid,
    output logic [31:0]                val,
    output dftc_pkg::side_t            side_out
);

    logic                              valid_reg [Passes];
    logic [31:0]                       mag_reg   [Passes];
    logic                              apply_reg [Passes];
    dftc_pkg::side_t                   side_reg  [Passes];
    logic [dftc_pkg::CorrW-1:0]        cur_reg   [Passes];

    for (genvar s = 0; s < Passes; s++) begin : g_pass
        logic                          v_in;
        logic [31:0]                   mag_in;
        logic                          apply_in;
        dftc_pkg::side_t               side_s;
        logic [dftc_pkg::CorrW-1:0]    cur_in;
        logic [15:0]                   y1;
        logic [14:0]                   y2;
        logic [32:0]                   p1;
        logic [29:0]                   p2;
        logic [8:0]                    q1;
        logic [4:0]                    q10;
        logic [dftc_pkg::CorrW-1:0]    cur_next;

        if (s == 0) begin : g_first
            assign v_in     = in_valid;
            assign mag_in   = mag;
            assign apply_in = apply;
            assign side_s   = side_in;
            assign cur_in   = mag[dftc_pkg::CorrW-1:0];
        end else begin : g_rest
            assign v_in     = valid_reg[s-1];
            assign mag_in   = mag_reg[s-1];
            assign apply_in = apply_reg[s-1];
            assign side_s   = side_reg[s-1];
            assign cur_in   = cur_reg[s-1];
        end

        always_comb
        begin
            y1  = cur_in[dftc_pkg::CorrW-1:3];
            y2  = cur_in[dftc_pkg::CorrW-1:4];
            p1  = 33'(y1) * 33'(dftc_pkg::Recip1800);
            p2  = 30'(y2) * 30'(dftc_pkg::Recip18000);
            q1  = p1[32:24];
            q10 = p2[29:25];
            cur_next = mag_in[dftc_pkg::CorrW-1:0]
                     + {9'(q1 - 9'(q10)), 1'b0};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            mag_reg[s]   <= mag_in;
            apply_reg[s] <= apply_in;
            side_reg[s]  <= side_s;
            cur_reg[s]   <= cur_next;
        end
    end

    assign out_valid = valid_reg[Passes-1];
    assign side_out  = side_reg[Passes-1];
    assign val       = apply_reg[Passes-1]
                     ? {{(32-dftc_pkg::CorrW){1'b0}}, cur_reg[Passes-1]}
                     : mag_reg[Passes-1];

endmodule
`default_nettype wire

// ----- rtl/core/dftc_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per pipeline stage.
module dftc_div #(
    parameter int DW = dftc_pkg::DivW,
    parameter int VW = dftc_pkg::DivisorW,
    parameter int SW = dftc_pkg::SideW
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [DW-1:0]      quotient,
    output logic [VW-1:0]      remainder,
    output logic [SW-1:0]      side_out
);

    logic          valid_reg [DW];
    logic [DW-1:0] dq_reg    [DW];
    logic [VW-1:0] rem_reg   [DW];
    logic [VW-1:0] dvs_reg   [DW];
    logic [SW-1:0] side_reg  [DW];

    for (genvar s = 0; s < DW; s++) begin : g_bit
        logic          v_in;
        logic [DW-1:0] dq_in;
        logic [VW-1:0] rem_in;
        logic [VW-1:0] dvs_in;
        logic [SW-1:0] side_s;
        logic [VW:0]   trial;
        logic          ge;
        logic [VW:0]   diff;
        logic [VW-1:0] rem_next;

        if (s == 0) begin : g_first
            assign v_in   = in_valid;
            assign dq_in  = dividend;
            assign rem_in = '0;
            assign dvs_in = divisor;
            assign side_s = side_in;
        end else begin : g_rest
            assign v_in   = valid_reg[s-1];
            assign dq_in  = dq_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign dvs_in = dvs_reg[s-1];
            assign side_s = side_reg[s-1];
        end

        always_comb
        begin
            trial    = {rem_in, dq_in[DW-1]};
            ge       = trial >= {1'b0, dvs_in};
            diff     = trial - {1'b0, dvs_in};
            rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dq_reg[s]   <= {dq_in[DW-2:0], ge};
            rem_reg[s]  <= rem_next;
            dvs_reg[s]  <= dvs_in;
            side_reg[s] <= side_s;
        end
    end

    assign out_valid = valid_reg[DW-1];
    assign quotient  = dq_reg[DW-1];
    assign remainder = rem_reg[DW-1];
    assign side_out  = side_reg[DW-1];

endmodule

// Divide by 60 in two stages: reciprocal multiply, then remainder.
module dftc_div60 #(
    parameter int SW = dftc_pkg::SideW
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [31:0]   dividend,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [31:0]        quotient,
    output logic [5:0]         remainder,
    output logic [SW-1:0]      side_out
);

    logic          a_valid_reg;
    logic [31:0]   a_dvd_reg;
    logic [26:0]   a_quo_reg;
    logic [SW-1:0] a_side_reg;
    logic          b_valid_reg;
    logic [26:0]   b_quo_reg;
    logic [5:0]    b_rem_reg;
    logic [SW-1:0] b_side_reg;
    logic [60:0]   prod;
    logic [5:0]    rem_next;

    always_comb
    begin
        prod     = 61'(dividend[31:2]) * 61'(dftc_pkg::Recip60);
        // true remainder is below 64, so six low bits are exact
        rem_next = a_dvd_reg[5:0] - 6'(a_quo_reg[5:0] * 6'(dftc_pkg::BaseSixty));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_dvd_reg  <= dividend;
        a_quo_reg  <= prod[60:34];
        a_side_reg <= side_in;
        b_quo_reg  <= a_quo_reg;
        b_rem_reg  <= rem_next;
        b_side_reg <= a_side_reg;
    end

    assign out_valid = b_valid_reg;
    assign quotient  = {5'b0, b_quo_reg};
    assign remainder = b_rem_reg;
    assign side_out  = b_side_reg;

endmodule
`default_nettype wire

// ----- rtl/core/drop_frame_timecode_split.sv -----
`default_nettype none
// Signed frame count to timecode. One conversion enters per clock (busy stays
// low) and its result appears on done after CorrPasses stages of drop-frame
// correction, a 32-stage bit-per-cycle divider by the frame rate, then two
// 2-stage reciprocal dividers by 60. The result is shown for one cycle only;
// the receiver cannot stall it. Frame rate and drop mode are sampled when the
// item is accepted.
module drop_frame_timecode_split #(
    parameter int CorrPasses = dftc_pkg::CorrPassesDefault
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [31:0]           frame_count,
    output logic                              done,
    output logic                              is_negative,
    output logic [19:0]                       hours,
    output logic [5:0]                        minutes,
    output logic [5:0]                        seconds,
    output logic [7:0]                        frames,
    output logic                              drop_separator,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [dftc_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [7:0]                   cfg_data
);

    localparam int Latency = CorrPasses + dftc_pkg::DivW + 4;
    localparam int SideW1  = dftc_pkg::SideW;
    localparam int SideW2  = SideW1 + 8;
    localparam int SideW3  = SideW2 + 6;

    logic [7:0] frame_rate_reg;
    logic       drop_mode_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rate_reg <= dftc_pkg::FrameRateReset;
            drop_mode_reg  <= dftc_pkg::DropModeReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dftc_pkg::RegFrameRate: frame_rate_reg <= cfg_data;
                dftc_pkg::RegDropMode:  drop_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic            accept;
    logic [31:0]     mag;
    logic            apply;
    dftc_pkg::side_t side0;

    assign accept = start && !busy;

    always_comb
    begin
        mag        = frame_count[31] ? 32'(-frame_count) : 32'(frame_count);
        apply      = drop_mode_reg && (frame_rate_reg == dftc_pkg::DfRate)
                   && (mag < dftc_pkg::DfLimit);
        side0.neg  = frame_count[31];
        side0.drop = drop_mode_reg;
        side0.rate = (frame_rate_reg == 8'd0) ? 8'd1 : frame_rate_reg;
    end

    logic            c_valid;
    logic [31:0]     c_val;
    dftc_pkg::side_t c_side;

    dftc_corr #(.Passes(CorrPasses)) u_corr (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .mag      (mag),
        .apply    (apply),
        .side_in  (side0),
        .out_valid(c_valid),
        .val      (c_val),
        .side_out (c_side)
    );

    logic              d1_valid;
    logic [31:0]       q1;
    logic [7:0]        r1;
    logic [SideW1-1:0] s1;

    dftc_div #(.SW(SideW1)) u_div_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c_valid),
        .dividend (c_val),
        .divisor  (c_side.rate),
        .side_in  (c_side),
        .out_valid(d1_valid),
        .quotient (q1),
        .remainder(r1),
        .side_out (s1)
    );

    logic              d2_valid;
    logic [31:0]       q2;
    logic [5:0]        r2;
    logic [SideW2-1:0] s2;

    dftc_div60 #(.SW(SideW2)) u_div_sec (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d1_valid),
        .dividend (q1),
        .side_in  ({r1, s1}),
        .out_valid(d2_valid),
        .quotient (q2),
        .remainder(r2),
        .side_out (s2)
    );

    logic              d3_valid;
    logic [31:0]       q3;
    logic [5:0]        r3;
    logic [SideW3-1:0] s3;
    dftc_pkg::side_t   side_fin;

    dftc_div60 #(.SW(SideW3)) u_div_min (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d2_valid),
        .dividend (q2),
        .side_in  ({r2, s2}),
        .out_valid(d3_valid),
        .quotient (q3),
        .remainder(r3),
        .side_out (s3)
    );

    assign side_fin       = s3[SideW1-1:0];
    assign done           = d3_valid;
    assign hours          = q3[19:0];
    assign minutes        = r3;
    assign seconds        = s3[SideW3-1:SideW2];
    assign frames         = s3[SideW2-1:SideW1];
    assign is_negative    = side_fin.neg;
    assign drop_separator = side_fin.drop;

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, Latency))
        else $error("result without a matching accepted item");

    a_minutes_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (minutes < 6'd60) && (seconds < 6'd60))
        else $error("minutes or seconds out of range");

    a_seconds_digit: assert property (@(posedge clk) disable iff (!rst_n)
        d2_valid |-> (r2 < 6'd60))
        else $error("seconds remainder out of range");

endmodule
`default_nettype wire
